// File: hw/rtl/vlpsr_pkg.sv
// Types and constants shared by the varint length-prefixed string reader.
`default_nettype none
package vlpsr_pkg;

	localparam int LEN_W   = 64;
	localparam int CAP_W   = 32;
	localparam int GROUP_W = 7;
	localparam int SH_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 32'd256;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_EOS    = 2'd1;
	localparam status_t ST_VARINT = 2'd2;
	localparam status_t ST_SMALL  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic [LEN_W-1:0] string_length;
		logic             string_done;
		status_t          status;
	} out_item_t;

	typedef struct packed {
		logic fire;
		logic has_result;
	} step_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/vlpsr_if.sv
// Valid/ready channel interfaces for the input bytes and the result items.
`default_nettype none
interface vlpsr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_last;

	modport source(output valid, output data_byte, output stream_last, input ready);
	modport sink(input valid, input data_byte, input stream_last, output ready);
endinterface

interface vlpsr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic [63:0] string_length;
	logic        string_done;
	logic [1:0]  status;

	modport source(output valid, output payload_byte, output payload_valid,
		output string_length, output string_done, output status, input ready);
	modport sink(input valid, input payload_byte, input payload_valid,
		input string_length, input string_done, input status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vlpsr_in_reg.sv
// Input register stage: holds one accepted byte until the decoder takes it.
`default_nettype none
module vlpsr_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	vlpsr_in_if.sink                stream,
	input  wire logic               fire,
	output vlpsr_pkg::in_item_t     item_s1,
	output logic                    valid_s1
);
	import vlpsr_pkg::*;

	logic accept;

	assign stream.ready = !valid_s1 || fire;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte   <= stream.data_byte;
			item_s1.stream_last <= stream.stream_last;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/vlpsr_decode.sv
// Length varint decoder, capacity check and payload counter with stream state.
`default_nettype none
module vlpsr_decode #(
	parameter int MAX_VARINT_BYTES = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [vlpsr_pkg::CAP_W-1:0] cfg_wdata,
	input  wire vlpsr_pkg::in_item_t       item_s1,
	input  wire logic                      fire,
	output logic                           has_result,
	output vlpsr_pkg::out_item_t           res
);
	import vlpsr_pkg::*;

	localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 2);

	logic [CAP_W-1:0] cap_q;
	logic             in_payload_q, in_payload_n;
	logic [LEN_W-1:0] acc_q, acc_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [LEN_W-1:0] remaining_q, remaining_n;
	logic             err_q, err_n;

	logic [7:0]       b;
	logic             last;
	logic [CNT_W-1:0] cnt_inc;
	logic [SH_W-1:0]  sh;
	logic [LEN_W-1:0] acc_new;

	assign b       = item_s1.data_byte;
	assign last    = item_s1.stream_last;
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign sh      = SH_W'(cnt_q) * SH_W'(GROUP_W);
	assign acc_new = acc_q | (LEN_W'(b[GROUP_W-1:0]) << sh);

	always_comb begin
		in_payload_n = in_payload_q;
		acc_n        = acc_q;
		cnt_n        = cnt_q;
		remaining_n  = remaining_q;
		err_n        = err_q;
		has_result   = 1'b0;
		res          = '0;

		if (err_q) begin
			has_result = 1'b0;
		end else if (in_payload_q) begin
			has_result          = 1'b1;
			res.payload_byte    = b;
			res.payload_valid   = 1'b1;
			res.string_length   = acc_q;
			remaining_n         = remaining_q - LEN_W'(1);
			if (remaining_q == LEN_W'(1)) begin
				res.string_done = 1'b1;
				in_payload_n    = 1'b0;
				acc_n           = '0;
				cnt_n           = '0;
			end else if (last) begin
				res.status = ST_EOS;
			end
		end else begin
			cnt_n = cnt_inc;
			if (cnt_inc > CNT_W'(MAX_VARINT_BYTES)) begin
				has_result        = 1'b1;
				res.string_length = acc_q;
				res.status        = ST_VARINT;
				err_n             = 1'b1;
			end else begin
				acc_n = acc_new;
				if (b[7]) begin
					has_result        = 1'b1;
					res.string_length = acc_new;
					if (acc_new >= LEN_W'(cap_q)) begin
						res.status = ST_SMALL;
						err_n      = 1'b1;
					end else if (acc_new == '0) begin
						res.string_done = 1'b1;
						acc_n           = '0;
						cnt_n           = '0;
					end else if (last) begin
						res.status = ST_EOS;
					end else begin
						remaining_n  = acc_new;
						in_payload_n = 1'b1;
					end
				end else if (last) begin
					has_result        = 1'b1;
					res.string_length = acc_new;
					res.status        = ST_EOS;
				end
			end
		end

		if (last) begin
			in_payload_n = 1'b0;
			acc_n        = '0;
			cnt_n        = '0;
			remaining_n  = '0;
			err_n        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			acc_q        <= '0;
			cnt_q        <= '0;
			remaining_q  <= '0;
			err_q        <= 1'b0;
		end else if (fire) begin
			in_payload_q <= in_payload_n;
			acc_q        <= acc_n;
			cnt_q        <= cnt_n;
			remaining_q  <= remaining_n;
			err_q        <= err_n;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/vlpsr_out_reg.sv
// Result register: holds one result item until the receiver takes it.
`default_nettype none
module vlpsr_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vlpsr_out_if.source               result,
	input  wire vlpsr_pkg::step_ctl_t ctl,
	input  wire vlpsr_pkg::out_item_t res,
	output logic                      free
);
	import vlpsr_pkg::*;

	logic      valid_q;
	out_item_t data_q;
	logic      load;

	assign free = !valid_q || result.ready;
	assign load = ctl.fire && ctl.has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign result.valid         = valid_q;
	assign result.payload_byte  = data_q.payload_byte;
	assign result.payload_valid = data_q.payload_valid;
	assign result.string_length = data_q.string_length;
	assign result.string_done   = data_q.string_done;
	assign result.status        = data_q.status;

endmodule
`default_nettype wire

// File: hw/rtl/varint_length_prefixed_string_reader.sv
// Top level of the varint length-prefixed string reader.
//
// Channels: stream takes one byte item per handshake (data_byte, stream_last);
// result gives at most one item per byte: a length item when a varint ends,
// a payload item for each string byte, or an error item. cfg_we/cfg_wdata
// write buffer_capacity (reset 256); write it only while the block is idle.
// Throughput: one byte item per cycle while result is not held, set by the
// single decode step between the input register and the result register.
// Path: a byte accepted into the input register is decoded and its result
// loaded into the result register, from which the receiver takes it.
// Bytes that give no result (a length byte without bit 7, bytes swallowed
// after an error) leave the input register at the next edge.
// Reset: both registers empty, decoder waiting for a length, no error, and
// the capacity back at 256.
// Stall: while result is held, the result register keeps its item, one more
// byte waits in the input register, and stream.ready drops; a byte that
// gives no result still passes through.
`default_nettype none
module varint_length_prefixed_string_reader #(
	parameter int MAX_VARINT_BYTES = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	vlpsr_in_if.sink         stream,
	vlpsr_out_if.source      result,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	import vlpsr_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      has_result;
	logic      out_free;
	out_item_t res;
	step_ctl_t ctl;

	assign ctl.fire       = valid_s1 && (!has_result || out_free);
	assign ctl.has_result = has_result;

	vlpsr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.fire     (ctl.fire),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	vlpsr_decode #(
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_s1    (item_s1),
		.fire       (ctl.fire),
		.has_result (has_result),
		.res        (res)
	);

	vlpsr_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.ctl    (ctl),
		.res    (res),
		.free   (out_free)
	);

	a_done_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.string_done && result.payload_valid
			|-> result.status == ST_OK)
		else $error("payload item marked done carries an error status");

	a_varint_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_VARINT
			|-> !result.payload_valid && !result.string_done)
		else $error("overlong varint item carries payload or done");

	a_no_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.payload_valid |-> result.payload_byte == 8'd0)
		else $error("length item carries a nonzero payload byte");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && has_result && !out_free |-> !stream.ready)
		else $error("input taken while the decoded byte cannot move");

endmodule
`default_nettype wire
